// ===== src/irc_fmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Formatting code decoder package
// Shared payload types and control byte codes for the chat text formatting
// code decoder and its channel interfaces.
// ----------------------------------------------------------------------------
package irc_fmt_pkg;

   localparam logic [7:0] CODE_BOLD      = 8'h02;
   localparam logic [7:0] CODE_COLOR     = 8'h03;
   localparam logic [7:0] CODE_BELL      = 8'h07;
   localparam logic [7:0] CODE_HIDDEN    = 8'h08;
   localparam logic [7:0] CODE_RESET     = 8'h0F;
   localparam logic [7:0] CODE_REVERSE   = 8'h16;
   localparam logic [7:0] CODE_ITALIC    = 8'h1D;
   localparam logic [7:0] CODE_STRIKE    = 8'h1E;
   localparam logic [7:0] CODE_UNDERLINE = 8'h1F;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;

   // Color index meaning "use the default color".
   localparam logic signed [7:0] COLOR_DEFAULT = -8'sd1;

   // Attribute flag positions.
   localparam int FLAG_BOLD      = 0;
   localparam int FLAG_ITALIC    = 1;
   localparam int FLAG_UNDERLINE = 2;
   localparam int FLAG_STRIKE    = 3;
   localparam int FLAG_REVERSE   = 4;
   localparam int FLAG_HIDDEN    = 5;
   localparam int FLAG_COUNT     = 6;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       line_start;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]        char_out;
      logic              is_bold;
      logic              is_italic;
      logic              is_underline;
      logic              is_strike;
      logic              is_reverse;
      logic              is_hidden;
      logic signed [7:0] fore_color;
      logic signed [7:0] back_color;
   } rsp_payload_type;

endpackage

// ===== src/irc_fmt_req_if.sv =====
// ----------------------------------------------------------------------------
// Formatting code decoder request channel
// Valid/ready channel that carries one raw message byte per transfer.
// ----------------------------------------------------------------------------
interface irc_fmt_req_if;
   logic                         valid;
   logic                         ready;
   irc_fmt_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/irc_fmt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Formatting code decoder response channel
// Valid/ready channel that carries one text byte and its attributes per
// transfer.
// ----------------------------------------------------------------------------
interface irc_fmt_rsp_if;
   logic                         valid;
   logic                         ready;
   irc_fmt_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/irc_format_code_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Formatting code decoder core
// Strips chat formatting control codes from a byte stream and tags each
// remaining text byte with the attributes and colors in force.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Per transfer
//   req_chan   in         one raw byte and a line start flag
//   rsp_chan   out        one text byte with six attribute flags and two colors
//
// Each byte passes through the decode stage, and a new byte can be taken
// every cycle while the output is not stalled; the bound is the single update of the format state.
// Each byte is held in the input register, then its response in the output register.
// Formatting control codes and bytes eaten by a color sequence produce no response.
// The synchronous reset clears the format state and both pipeline stages.
// A stalled response holds the output register, and the input register and
// request ready back up behind it only while the output is still occupied.
// ----------------------------------------------------------------------------
module irc_format_code_decoder_core (
   input logic               clock,
   input logic               reset,
   irc_fmt_req_if.sink       req_chan,
   irc_fmt_rsp_if.source     rsp_chan
);

   // Color sequence progress. The background phases remember whether any
   // foreground digits were given before the comma.
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FG,
      PH_BG_NOF,
      PH_BG_F
   } phase_type;

   // Input register stage.
   logic                         in_valid_ff;
   irc_fmt_pkg::req_payload_type in_data_ff;

   // Format state.
   logic [irc_fmt_pkg::FLAG_COUNT-1:0] attr_ff, attr_in;
   logic signed [7:0]                  fore_ff, fore_in;
   logic signed [7:0]                  back_ff, back_in;
   phase_type                          phase_ff, phase_in;
   logic [6:0]                         fore_acc_ff, fore_acc_in;
   logic [6:0]                         back_acc_ff, back_acc_in;
   logic [1:0]                         digits_ff, digits_in;

   // Output register stage.
   logic                         out_valid_ff;
   irc_fmt_pkg::rsp_payload_type out_data_ff;

   logic                         emit;
   irc_fmt_pkg::rsp_payload_type result;
   logic                         advance;

   // The decode stage moves on whenever the output register is free or is
   // being drained in this cycle.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   always_comb begin
      logic [7:0] b;
      logic       is_digit;
      logic       handled;
      logic [7:0] acc_sum;

      b        = in_data_ff.byte_in;
      is_digit = (b >= irc_fmt_pkg::CHAR_ZERO) && (b <= irc_fmt_pkg::CHAR_NINE);
      handled  = 1'b0;
      emit     = 1'b0;
      acc_sum  = 8'd0;

      attr_in     = attr_ff;
      fore_in     = fore_ff;
      back_in     = back_ff;
      phase_in    = phase_ff;
      fore_acc_in = fore_acc_ff;
      back_acc_in = back_acc_ff;
      digits_in   = digits_ff;

      // A new message drops all formatting and any open color sequence.
      if (in_data_ff.line_start) begin
         attr_in     = '0;
         fore_in     = irc_fmt_pkg::COLOR_DEFAULT;
         back_in     = irc_fmt_pkg::COLOR_DEFAULT;
         phase_in    = PH_IDLE;
         fore_acc_in = '0;
         back_acc_in = '0;
         digits_in   = '0;
      end

      unique case (phase_in)
         PH_FG: begin
            if (is_digit && digits_in < 2'd2) begin
               acc_sum     = 8'({1'b0, fore_acc_in} * 8'd10) + {4'd0, b[3:0]};
               fore_acc_in = acc_sum[6:0];
               digits_in   = digits_in + 2'd1;
               handled     = 1'b1;
            end else if (b == irc_fmt_pkg::CHAR_COMMA) begin
               phase_in    = (digits_in != 2'd0) ? PH_BG_F : PH_BG_NOF;
               digits_in   = '0;
               back_acc_in = '0;
               handled     = 1'b1;
            end else begin
               if (digits_in == 2'd0) begin
                  fore_in = irc_fmt_pkg::COLOR_DEFAULT;
                  back_in = irc_fmt_pkg::COLOR_DEFAULT;
               end else begin
                  fore_in = {1'b0, fore_acc_in};
               end
               phase_in  = PH_IDLE;
               digits_in = '0;
            end
         end
         PH_BG_NOF, PH_BG_F: begin
            if (is_digit && digits_in < 2'd2) begin
               acc_sum     = 8'({1'b0, back_acc_in} * 8'd10) + {4'd0, b[3:0]};
               back_acc_in = acc_sum[6:0];
               digits_in   = digits_in + 2'd1;
               handled     = 1'b1;
            end else begin
               if (phase_in == PH_BG_NOF && digits_in == 2'd0) begin
                  // A lone comma after the color code resets both colors.
                  fore_in = irc_fmt_pkg::COLOR_DEFAULT;
                  back_in = irc_fmt_pkg::COLOR_DEFAULT;
               end else begin
                  if (phase_in == PH_BG_F) begin
                     fore_in = {1'b0, fore_acc_in};
                  end
                  if (digits_in != 2'd0) begin
                     back_in = {1'b0, back_acc_in};
                  end
               end
               phase_in  = PH_IDLE;
               digits_in = '0;
            end
         end
         PH_IDLE: begin
         end
         default: begin
         end
      endcase

      // The byte that closed a color sequence is decoded like any other.
      if (!handled) begin
         unique case (b)
            irc_fmt_pkg::CODE_BOLD:
               attr_in[irc_fmt_pkg::FLAG_BOLD] = !attr_in[irc_fmt_pkg::FLAG_BOLD];
            irc_fmt_pkg::CODE_ITALIC:
               attr_in[irc_fmt_pkg::FLAG_ITALIC] = !attr_in[irc_fmt_pkg::FLAG_ITALIC];
            irc_fmt_pkg::CODE_UNDERLINE:
               attr_in[irc_fmt_pkg::FLAG_UNDERLINE] =
                  !attr_in[irc_fmt_pkg::FLAG_UNDERLINE];
            irc_fmt_pkg::CODE_STRIKE:
               attr_in[irc_fmt_pkg::FLAG_STRIKE] = !attr_in[irc_fmt_pkg::FLAG_STRIKE];
            irc_fmt_pkg::CODE_REVERSE:
               attr_in[irc_fmt_pkg::FLAG_REVERSE] = !attr_in[irc_fmt_pkg::FLAG_REVERSE];
            irc_fmt_pkg::CODE_HIDDEN:
               attr_in[irc_fmt_pkg::FLAG_HIDDEN] = !attr_in[irc_fmt_pkg::FLAG_HIDDEN];
            irc_fmt_pkg::CODE_RESET: begin
               attr_in = '0;
               fore_in = irc_fmt_pkg::COLOR_DEFAULT;
               back_in = irc_fmt_pkg::COLOR_DEFAULT;
            end
            irc_fmt_pkg::CODE_BELL: begin
            end
            irc_fmt_pkg::CODE_COLOR: begin
               phase_in    = PH_FG;
               fore_acc_in = '0;
               back_acc_in = '0;
               digits_in   = '0;
            end
            default:
               emit = 1'b1;
         endcase
      end

      result.char_out     = b;
      result.is_bold      = attr_in[irc_fmt_pkg::FLAG_BOLD];
      result.is_italic    = attr_in[irc_fmt_pkg::FLAG_ITALIC];
      result.is_underline = attr_in[irc_fmt_pkg::FLAG_UNDERLINE];
      result.is_strike    = attr_in[irc_fmt_pkg::FLAG_STRIKE];
      result.is_reverse   = attr_in[irc_fmt_pkg::FLAG_REVERSE];
      result.is_hidden    = attr_in[irc_fmt_pkg::FLAG_HIDDEN];
      result.fore_color   = fore_in;
      result.back_color   = back_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         attr_ff      <= '0;
         fore_ff      <= irc_fmt_pkg::COLOR_DEFAULT;
         back_ff      <= irc_fmt_pkg::COLOR_DEFAULT;
         phase_ff     <= PH_IDLE;
         fore_acc_ff  <= '0;
         back_acc_ff  <= '0;
         digits_ff    <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
            in_data_ff  <= req_chan.payload;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff && emit;
            if (in_valid_ff) begin
               out_data_ff <= result;
               attr_ff     <= attr_in;
               fore_ff     <= fore_in;
               back_ff     <= back_in;
               phase_ff    <= phase_in;
               fore_acc_ff <= fore_acc_in;
               back_acc_ff <= back_acc_in;
               digits_ff   <= digits_in;
            end
         end
      end
   end

endmodule
